@@ sv/xcfd_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfd_pkg
// Types and codes shared by the deframer controller, datapath and top level.
// ----------------------------------------------------------------------------
package xcfd_pkg;

	localparam logic REG_START = 1'b0;
	localparam logic REG_END   = 1'b1;

	typedef enum logic [3:0] {
		ST_HUNT,
		ST_DEST,
		ST_SRC,
		ST_KIND,
		ST_LEN,
		ST_DATA,
		ST_CHECK,
		ST_END,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_DEST,
		OP_SRC,
		OP_KIND,
		OP_LEN,
		OP_DATA,
		OP_EMIT_INIT,
		OP_EMIT_LOAD
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic start_hit;
		logic id_done;
		logic len_done;
		logic len_big;
		logic len_zero;
		logic data_done;
		logic check_ok;
		logic end_hit;
		logic emit_last;
		logic out_free;
	} sts_t;

endpackage

@@ sv/xcfd_if.sv @@
// ----------------------------------------------------------------------------
// xcfd_if
// Valid/ready channels: received bytes in, frame result beats out.
// ----------------------------------------------------------------------------
interface xcfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfd_frame_if;
	logic        valid;
	logic        ready;
	logic [31:0] dest_node;
	logic [31:0] src_node;
	logic [7:0]  frame_kind;
	logic [5:0]  payload_len;
	logic        has_data;
	logic [4:0]  byte_pos;
	logic [7:0]  data_byte;
	logic        last;

	modport source (output valid, output dest_node, output src_node, output frame_kind,
		output payload_len, output has_data, output byte_pos, output data_byte,
		output last, input ready);
	modport sink   (input valid, input dest_node, input src_node, input frame_kind,
		input payload_len, input has_data, input byte_pos, input data_byte,
		input last, output ready);
endinterface

@@ sv/xcfd_ctrl.sv @@
// ----------------------------------------------------------------------------
// xcfd_ctrl
// Frame parsing state machine; issues at most one datapath command per cycle.
// ----------------------------------------------------------------------------
module xcfd_ctrl
	import xcfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic rx_valid,
	output logic rx_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		rx_ready = 1'b1;
		acc      = rx_valid;
		unique case (state_q)
			ST_HUNT: begin
				if (acc && sts.start_hit) begin
					cmd.op  = OP_START;
					state_d = ST_DEST;
				end
			end
			ST_DEST: begin
				if (acc) begin
					cmd.op = OP_DEST;
					if (sts.id_done) state_d = ST_SRC;
				end
			end
			ST_SRC: begin
				if (acc) begin
					cmd.op = OP_SRC;
					if (sts.id_done) state_d = ST_KIND;
				end
			end
			ST_KIND: begin
				if (acc) begin
					cmd.op  = OP_KIND;
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (acc) begin
					cmd.op = OP_LEN;
					if (sts.len_done) begin
						if (sts.len_big)       state_d = ST_HUNT;
						else if (sts.len_zero) state_d = ST_CHECK;
						else                   state_d = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (acc) begin
					cmd.op = OP_DATA;
					if (sts.data_done) state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (acc) state_d = sts.check_ok ? ST_END : ST_HUNT;
			end
			ST_END: begin
				if (acc) begin
					if (sts.end_hit) begin
						cmd.op  = OP_EMIT_INIT;
						state_d = ST_EMIT_RD;
					end else begin
						state_d = ST_HUNT;
					end
				end
			end
			ST_EMIT_RD: begin
				rx_ready = 1'b0;
				acc      = 1'b0;
				state_d  = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				rx_ready = 1'b0;
				acc      = 1'b0;
				if (sts.out_free) begin
					cmd.op  = OP_EMIT_LOAD;
					state_d = sts.emit_last ? ST_HUNT : ST_EMIT_RD;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase
	end

endmodule

@@ sv/xcfd_dp.sv @@
// ----------------------------------------------------------------------------
// xcfd_dp
// Header registers, running XOR, payload buffer and result output register.
// ----------------------------------------------------------------------------
module xcfd_dp
	import xcfd_pkg::*;
#(
	parameter int PAYLOAD_MAX   = 32,
	parameter int NODE_ID_BYTES = 4,
	parameter int LEN_BYTES     = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_data,
	input  logic [7:0] rx_byte,
	input  cmd_t       cmd,
	output sts_t       sts,
	xcfd_frame_if.source tx
);

	localparam int CNT_MAX = (PAYLOAD_MAX > 4) ? PAYLOAD_MAX : 4;
	localparam int CW      = $clog2(CNT_MAX + 1);
	localparam int AW      = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
	localparam int LW      = 8 * LEN_BYTES;
	localparam int CMPW    = ((CW > LW) ? CW : LW) + 1;

	logic [7:0]    start_q;
	logic [7:0]    end_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic [31:0]   dest_q;
	logic [31:0]   src_q;
	logic [7:0]    kind_q;
	logic [LW-1:0] len_q;
	logic [7:0]    xor_q;
	logic [7:0]    rdata_q;
	logic [7:0]    mem_q [PAYLOAD_MAX];

	logic [LW-1:0]   len_next;
	logic [CMPW-1:0] cnt_inc;
	logic            len_zero;
	logic            at_len;

	assign len_next = len_q | (LW'(rx_byte) << {cnt_q[0], 3'b000});
	assign cnt_inc  = CMPW'(cnt_q) + CMPW'(1);
	assign len_zero = (len_q == '0);
	assign at_len   = (cnt_inc >= CMPW'(len_q));

	assign sts.start_hit = (rx_byte == start_q);
	assign sts.id_done   = (cnt_q == CW'(NODE_ID_BYTES - 1));
	assign sts.len_done  = (cnt_q == CW'(LEN_BYTES - 1));
	assign sts.len_big   = (len_next > LW'(PAYLOAD_MAX));
	assign sts.len_zero  = (len_next == '0);
	assign sts.data_done = at_len;
	assign sts.check_ok  = (rx_byte == xor_q);
	assign sts.end_hit   = (rx_byte == end_q);
	assign sts.emit_last = len_zero || at_len;
	assign sts.out_free  = !out_valid_q || tx.ready;

	assign tx.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			end_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_START: start_q <= cfg_data;
					REG_END:   end_q   <= cfg_data;
					default:   ;
				endcase
			end
			case (cmd.op)
				OP_START, OP_EMIT_INIT: cnt_q <= '0;
				OP_DEST, OP_SRC:        cnt_q <= sts.id_done ? '0 : cnt_q + CW'(1);
				OP_LEN:                 cnt_q <= sts.len_done ? '0 : cnt_q + CW'(1);
				OP_DATA, OP_EMIT_LOAD:  cnt_q <= cnt_q + CW'(1);
				default:                ;
			endcase
			if (cmd.op == OP_EMIT_LOAD) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[cnt_q[AW-1:0]];
		case (cmd.op)
			OP_START: begin
				dest_q <= '0;
				src_q  <= '0;
				kind_q <= '0;
				len_q  <= '0;
				xor_q  <= rx_byte;
			end
			OP_DEST: begin
				dest_q[{cnt_q[1:0], 3'b000} +: 8] <= rx_byte;
				xor_q <= xor_q ^ rx_byte;
			end
			OP_SRC: begin
				src_q[{cnt_q[1:0], 3'b000} +: 8] <= rx_byte;
				xor_q <= xor_q ^ rx_byte;
			end
			OP_KIND: begin
				kind_q <= rx_byte;
				xor_q  <= xor_q ^ rx_byte;
			end
			OP_LEN: begin
				len_q <= len_next;
				xor_q <= xor_q ^ rx_byte;
			end
			OP_DATA: begin
				mem_q[cnt_q[AW-1:0]] <= rx_byte;
				xor_q <= xor_q ^ rx_byte;
			end
			OP_EMIT_LOAD: begin
				tx.dest_node   <= dest_q;
				tx.src_node    <= src_q;
				tx.frame_kind  <= kind_q;
				tx.payload_len <= len_q[5:0];
				tx.has_data    <= !len_zero;
				tx.byte_pos    <= len_zero ? 5'd0 : 5'(cnt_q);
				tx.data_byte   <= len_zero ? 8'd0 : rdata_q;
				tx.last        <= sts.emit_last;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/xor_checked_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_deframer
// Start/end delimited byte frame parser with XOR check byte.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while parsing (start byte, little-endian
// destination and source ids, type byte, length, payload, XOR check byte,
// end byte). Oversized lengths, check mismatches and wrong end bytes drop the
// frame. A good frame is emitted after its end byte as one beat per payload
// byte (or one empty beat for a zero-length frame); each beat goes through a
// read state and a load state as the payload buffer has a registered read
// port; rx.ready stays low during emission. Beats stall on tx.ready through
// an output register, and byte intake resumes while the last beat waits.
module xor_checked_frame_deframer
	import xcfd_pkg::*;
#(
	parameter int PAYLOAD_MAX   = 32,
	parameter int NODE_ID_BYTES = 4,
	parameter int LEN_BYTES     = 1
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_idx,
	input  logic [7:0] cfg_data,
	xcfd_byte_if.sink    rx,
	xcfd_frame_if.source tx
);

	cmd_t cmd;
	sts_t sts;

	xcfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	xcfd_dp #(
		.PAYLOAD_MAX   (PAYLOAD_MAX),
		.NODE_ID_BYTES (NODE_ID_BYTES),
		.LEN_BYTES     (LEN_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rx_byte  (rx.rx_byte),
		.cmd      (cmd),
		.sts      (sts),
		.tx       (tx)
	);

	a_load_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT_LOAD |-> sts.out_free)
		else $error("result loaded over a waiting beat");

	a_no_intake_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT_LOAD |-> !rx.ready)
		else $error("byte intake during emission");

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid && !tx.has_data |-> tx.last && tx.byte_pos == 5'd0 && tx.data_byte == 8'd0)
		else $error("malformed empty-frame beat");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EMIT_LOAD |=> tx.valid)
		else $error("loaded beat not presented");

endmodule
